### rtl/core/fcfl_pkg.sv
package fcfl_pkg;

    // Field widths fixed by the item format
    localparam int CNT_W       = 11;
    localparam int IDX_IN_W    = 10;
    localparam int IDX_OUT_W   = 10;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int TDATA_W     = 16;

    localparam int MAX_CHUNKS_DEFAULT = 1024;
    localparam logic [CNT_W-1:0] CHUNK_COUNT_RESET = CNT_W'(1024);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_FREE_ALL = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_NULL   = 2'd2,
        STAT_BOUNDS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC_RD,
        ST_FILL,
        ST_RESP
    } state_t;

endpackage

### rtl/core/fixed_chunk_free_list_pool.sv
// Flow: free, null or out-of-bounds free, allocate on an empty pool and the unused
// command are registered at the output from idle; allocate first does one registered
// link-memory read; free all first writes n links in ST_FILL, n = min(count, MAX).
// Throughput: a new item every cycle for free and the no-op cases while the output is free;
// one item in flight: allocate and free all stall input until done, as does a held result.
// Reset: head = empty marker, chunk count = 1024, output empty; link memory not cleared.
module fixed_chunk_free_list_pool
    import fcfl_pkg::*;
#(
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_wdata,      // chunk_count

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,   // [9:0] free_index, rest zero
    input  logic [2:0]            s_axis_tuser,   // [1:0] command, [2] null_pointer

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,   // [9:0] alloc_index, rest zero
    output logic [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

    // Link entries and the head hold a chunk index or the empty marker (MAX_CHUNKS)
    localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int LINK_W = $clog2(MAX_CHUNKS + 1);
    localparam int CMP_W  = (LINK_W > CNT_W) ? LINK_W : CNT_W;
    localparam logic [LINK_W-1:0] LIST_EMPTY = LINK_W'(MAX_CHUNKS);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        chunk_count_reg;
    logic [LINK_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]        fill_reg, fill_next;
    logic [LINK_W-1:0]       rd_data_reg;

    // Pending result when the output register is still occupied
    status_t                 res_status_reg;
    logic [IDX_OUT_W-1:0]    res_index_reg;

    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic [IDX_OUT_W-1:0]    out_index_reg;

    // Link memory: one synchronous read port, one write port
    logic [LINK_W-1:0]       link_mem [MAX_CHUNKS];

    // ---------------------------------------------------------------
    // Decoded input item
    // ---------------------------------------------------------------
    cmd_t                    in_cmd;
    logic [IDX_IN_W-1:0]     in_index;
    logic                    in_null;
    logic                    accept;

    assign in_cmd   = cmd_t'(s_axis_tuser[CMD_W-1:0]);
    assign in_index = s_axis_tdata[IDX_IN_W-1:0];
    assign in_null  = s_axis_tuser[CMD_W];

    // One item in flight at a time; the output register decouples the sink
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Effective chunk count, saturated to the pool size
    logic [CMP_W-1:0] cnt_ext, live_n;
    logic             head_empty;
    logic             free_oob;
    logic             fill_last;

    assign cnt_ext    = CMP_W'(chunk_count_reg);
    assign live_n     = (cnt_ext > CMP_W'(MAX_CHUNKS)) ? CMP_W'(MAX_CHUNKS) : cnt_ext;
    assign head_empty = (head_reg == LIST_EMPTY);
    assign free_oob   = (CMP_W'(in_index) >= live_n);
    assign fill_last  = (CMP_W'(fill_reg) == (live_n - CMP_W'(1)));

    // Output slot can take a result this cycle
    logic slot_free;
    assign slot_free = !out_valid_reg || m_axis_tready;

    // ---------------------------------------------------------------
    // Datapath control
    // ---------------------------------------------------------------
    logic                 done;
    status_t              done_status;
    logic [IDX_OUT_W-1:0] done_index;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [LINK_W-1:0]    wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;

    always_comb
    begin
        done        = 1'b0;
        done_status = STAT_OK;
        done_index  = '0;
        wr_en       = 1'b0;
        wr_addr     = fill_reg;
        wr_data     = LIST_EMPTY;
        rd_en       = 1'b0;
        rd_addr     = head_reg[IDX_W-1:0];
        head_next   = head_reg;
        fill_next   = fill_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_cmd)
                        CMD_ALLOC:
                        begin
                            if (head_empty)
                            begin
                                done        = 1'b1;
                                done_status = STAT_EMPTY;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                            end
                        end
                        CMD_FREE:
                        begin
                            done = 1'b1;
                            if (in_null)
                            begin
                                done_status = STAT_NULL;
                            end
                            else if (free_oob)
                            begin
                                done_status = STAT_BOUNDS;
                            end
                            else
                            begin
                                // push: link the chunk to the old head
                                wr_en     = 1'b1;
                                wr_addr   = IDX_W'(in_index);
                                wr_data   = head_reg;
                                head_next = LINK_W'(in_index);
                            end
                        end
                        CMD_FREE_ALL:
                        begin
                            head_next = LIST_EMPTY;
                            fill_next = '0;
                            if (live_n == '0)
                            begin
                                done = 1'b1;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            ST_ALLOC_RD:
            begin
                // pop: link of the old head becomes the new head
                done       = 1'b1;
                done_index = IDX_OUT_W'(head_reg);
                head_next  = rd_data_reg;
            end
            ST_FILL:
            begin
                // entry i links to i-1, entry 0 ends the list
                wr_en   = 1'b1;
                wr_addr = fill_reg;
                wr_data = (fill_reg == '0) ? LIST_EMPTY : (LINK_W'(fill_reg) - LINK_W'(1));
                if (fill_last)
                begin
                    head_next = LINK_W'(fill_reg);
                    done      = 1'b1;
                end
                else
                begin
                    fill_next = fill_reg + IDX_W'(1);
                end
            end
            ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (done)
                    begin
                        state_next = slot_free ? ST_IDLE : ST_RESP;
                    end
                    else if (in_cmd == CMD_ALLOC)
                    begin
                        state_next = ST_ALLOC_RD;
                    end
                    else
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_ALLOC_RD:
            begin
                state_next = slot_free ? ST_IDLE : ST_RESP;
            end
            ST_FILL:
            begin
                if (done)
                begin
                    state_next = slot_free ? ST_IDLE : ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            chunk_count_reg <= CHUNK_COUNT_RESET;
            head_reg        <= LIST_EMPTY;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            if (cfg_we)
            begin
                chunk_count_reg <= cfg_wdata;
            end
            if ((done || (state_reg == ST_RESP)) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fill_reg <= fill_next;
        if (done && !slot_free)
        begin
            res_status_reg <= done_status;
            res_index_reg  <= done_index;
        end
        if (done && slot_free)
        begin
            out_status_reg <= done_status;
            out_index_reg  <= done_index;
        end
        else if ((state_reg == ST_RESP) && slot_free)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
        end
    end

    // Link memory; reads and writes never target the same cycle since the
    // sequencer issues at most one access per item step
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_index_reg);
    assign m_axis_tuser  = out_status_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LIST_EMPTY)
        else $error("head beyond empty marker");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (CMP_W'(fill_reg) < live_n))
        else $error("fill index beyond chunk count");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_cmd == CMD_ALLOC) && head_empty)
            |=> (out_valid_reg || (state_reg == ST_RESP)))
        else $error("empty allocate lost its result");

    a_empty_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STAT_OK)) |-> (out_index_reg == '0))
        else $error("failed command returned an index");

    a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC_RD) |=> (head_reg == $past(rd_data_reg)))
        else $error("allocate did not advance head");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import fcfl_pkg::*;

    // Pool geometry as built, and the empty-list marker
    localparam int                POOL_MAX    = MAX_CHUNKS_DEFAULT;
    localparam logic [CNT_W-1:0]  LIST_END    = CNT_W'(POOL_MAX);
    // Command code the block leaves unused; it must answer ok and change nothing
    localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
    // Idle margin after the last predicted result has come back
    localparam int                SETTLE_CYCLES = 4;
    localparam int                HOLD_CYCLES   = 300;
    localparam int                CYCLE_LIMIT   = 600000;
    localparam int                RANDOM_ITEMS  = 600;

    typedef struct packed {
        status_t                status;
        logic [IDX_OUT_W-1:0]   index;
    } pool_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CNT_W-1:0]       cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata = '0;   // [9:0] free_index, rest zero
    logic [2:0]             s_axis_tuser = '0;   // [1:0] command, [2] null_pointer
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     m_axis_tdata;        // [9:0] alloc_index, rest zero
    logic [STATUS_W-1:0]    m_axis_tuser;        // [1:0] status

    fixed_chunk_free_list_pool u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the pool: count register, head, per-chunk links
    logic [CNT_W-1:0]       shadow_count = CHUNK_COUNT_RESET;
    logic [CNT_W-1:0]       shadow_head  = LIST_END;
    logic [CNT_W-1:0]       shadow_link [POOL_MAX];

    pool_result_t           pending_results [$];  // predicted, not yet seen at output
    logic [IDX_OUT_W-1:0]   handed_out [$];       // chunks the pool gave out, for clean frees

    int     src_idle_pct = 0;
    int     snk_idle_pct = 0;
    bit     hold_req = 1'b0;
    bit     hold_on  = 1'b0;
    int     error_count = 0;
    int     cycle_count = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     rebuilds = 0;
    int     count_writes = 0;

    initial begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver-side long hold, counted here so the sender keeps pushing meanwhile
    initial begin
        forever
        begin
            wait (hold_req);
            hold_on = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on  = 1'b0;
            hold_req = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= !hold_on && ($urandom_range(99) >= snk_idle_pct);
    end

    // Effective count saturates at the pool size
    function automatic logic [CNT_W-1:0] live_chunks();
        return (shadow_count > LIST_END) ? LIST_END : shadow_count;
    endfunction

    // Apply one command to the shadow pool and return what the block must answer
    function automatic pool_result_t predict_pool_op(input logic [CMD_W-1:0] cmd,
                                                     input logic [IDX_IN_W-1:0] idx,
                                                     input logic is_null);
        pool_result_t       res;
        logic [CNT_W-1:0]   n;
        res.status = STAT_OK;
        res.index  = '0;
        n = live_chunks();
        case (cmd)
            CMD_ALLOC:
            begin
                if (shadow_head >= LIST_END)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.index   = shadow_head[IDX_OUT_W-1:0];
                    shadow_head = shadow_link[shadow_head[IDX_IN_W-1:0]];
                end
            end
            CMD_FREE:
            begin
                if (is_null)
                    res.status = STAT_NULL;
                else if (CNT_W'(idx) >= n)
                    res.status = STAT_BOUNDS;
                else
                begin
                    shadow_link[idx] = shadow_head;
                    shadow_head      = CNT_W'(idx);
                end
            end
            CMD_FREE_ALL:
            begin
                // rebuilt list: highest index at the head, each link one lower
                shadow_head = LIST_END;
                for (int i = 0; i < n; i++)
                begin
                    shadow_link[i] = shadow_head;
                    shadow_head    = CNT_W'(i);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offer one item; valid stays high on return so back-to-back items need no gap
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_IN_W-1:0] idx,
                             input logic is_null);
        pool_result_t res;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(idx);
        s_axis_tuser  <= {is_null, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = predict_pool_op(cmd, idx, is_null);
        pending_results.push_back(res);
        items_sent++;
        if (cmd == CMD_FREE_ALL)
        begin
            handed_out.delete();
            rebuilds++;
        end
        else if (cmd == CMD_ALLOC && res.status == STAT_OK)
            handed_out.push_back(res.index);
    endtask

    // Sender goes quiet until every predicted result has come back
    task automatic wait_quiet();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_chunk_count(input logic [CNT_W-1:0] value);
        wait_quiet();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_count = value;
        count_writes++;
    endtask

    // Output checker: every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d alloc_index %0d",
                       m_axis_tuser, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata !== TDATA_W'(want.index))
                begin
                    $error("alloc_index: expected %0d, got %0d", want.index, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    // Pool not built yet: allocate is empty, a single free seeds the list
    task automatic test_after_reset();
        send_item(CMD_ALLOC, 10'd0, 1'b0);
        send_item(CMD_FREE, 10'd1023, 1'b1);
        send_item(CMD_UNUSED, 10'h2AA, 1'b1);
        send_item(CMD_FREE, 10'd5, 1'b0);
        send_item(CMD_ALLOC, 10'h155, 1'b0);
        send_item(CMD_ALLOC, 10'd0, 1'b0);
    endtask

    // Full-size rebuild, LIFO order, index extremes
    task automatic test_full_pool();
        write_chunk_count(11'd1024);
        send_item(CMD_FREE_ALL, 10'd0, 1'b0);
        send_item(CMD_ALLOC, 10'd0, 1'b0);
        send_item(CMD_ALLOC, 10'd0, 1'b0);
        send_item(CMD_FREE, 10'd0, 1'b0);
        send_item(CMD_FREE, 10'd1023, 1'b0);
        send_item(CMD_ALLOC, 10'd0, 1'b0);
        send_item(CMD_ALLOC, 10'd0, 1'b0);
        send_item(CMD_FREE, 10'd0, 1'b1);
    endtask

    // Count of one, zero, saturating wide count, and a count shrunk after a rebuild
    task automatic test_count_edges();
        write_chunk_count(11'd1);
        send_item(CMD_FREE_ALL, 10'd0, 1'b0);
        send_item(CMD_ALLOC, 10'd0, 1'b0);
        send_item(CMD_ALLOC, 10'd0, 1'b0);
        send_item(CMD_FREE, 10'd1, 1'b0);
        write_chunk_count(11'd0);
        send_item(CMD_FREE_ALL, 10'd0, 1'b0);
        send_item(CMD_FREE, 10'd0, 1'b0);
        write_chunk_count(11'd2047);
        send_item(CMD_FREE, 10'd1023, 1'b0);
        send_item(CMD_ALLOC, 10'd0, 1'b0);
        write_chunk_count(11'd1024);
        send_item(CMD_FREE_ALL, 10'd0, 1'b0);
        write_chunk_count(11'd3);
        send_item(CMD_ALLOC, 10'd0, 1'b0);   // old list still hands out 1023
        send_item(CMD_FREE, 10'd5, 1'b0);
    endtask

    // Mostly small pools so rebuilds stay short; the extremes now and then
    function automatic logic [CNT_W-1:0] pick_chunk_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return 11'd0;
        else if (roll < 10)
            return 11'd1;
        else if (roll < 14)
            return 11'd2047;
        else if (roll < 18)
            return 11'd1024;
        else if (roll < 20)
            return 11'd1025;
        else if (roll < 22)
            return 11'd1023;
        return CNT_W'($urandom_range(64, 2));
    endfunction

    // Alloc/free traffic with frees mostly of chunks really handed out
    task automatic test_random_traffic(input int n_items, input int src_pct, input int snk_pct);
        int                     roll;
        int                     pos;
        logic [IDX_IN_W-1:0]    idx;
        logic [CNT_W-1:0]       n;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 150 == 0)
            begin
                write_chunk_count(pick_chunk_count());
                send_item(CMD_FREE_ALL, IDX_IN_W'($urandom), 1'b0);
            end
            roll = $urandom_range(99);
            n    = live_chunks();
            if (roll < 42)
                send_item(CMD_ALLOC, IDX_IN_W'($urandom), 1'(($urandom)));
            else if (roll < 80 && handed_out.size() != 0)
            begin
                pos = $urandom_range(handed_out.size() - 1);
                idx = handed_out[pos];
                handed_out.delete(pos);
                send_item(CMD_FREE, idx, 1'b0);
            end
            else if (roll < 90)
            begin
                // may land out of range, or be a double free
                if ($urandom_range(1) == 0 || n == 0)
                    idx = IDX_IN_W'($urandom_range(1023));
                else
                    idx = IDX_IN_W'($urandom_range(n - 1));
                send_item(CMD_FREE, idx, 1'b0);
            end
            else if (roll < 94)
                send_item(CMD_FREE, IDX_IN_W'($urandom_range(1023)), 1'b1);
            else if (roll < 97)
                send_item(CMD_FREE_ALL, IDX_IN_W'($urandom), 1'b0);
            else
                send_item(CMD_UNUSED, IDX_IN_W'($urandom), 1'(($urandom)));
        end
        wait_quiet();
    endtask

    // Receiver stops for a long stretch while items keep coming: input must stall
    task automatic test_receiver_hold();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_chunk_count(11'd16);
        send_item(CMD_FREE_ALL, 10'd0, 1'b0);
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++)
        begin
            if (k % 3 == 2 && handed_out.size() != 0)
                send_item(CMD_FREE, handed_out.pop_front(), 1'b0);
            else
                send_item(CMD_ALLOC, IDX_IN_W'($urandom), 1'b0);
        end
        wait_quiet();
    endtask

    initial begin
        src_idle_pct = 31;
        snk_idle_pct = 88;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_full_pool();
        test_count_edges();
        test_random_traffic(RANDOM_ITEMS, 31, 88);
        test_random_traffic(RANDOM_ITEMS, 88, 31);
        test_random_traffic(RANDOM_ITEMS, 0, 0);
        test_receiver_hold();
        wait_quiet();

        $display("Coverage: %0d items, %0d results, %0d rebuilds, %0d chunk count writes",
                 items_sent, results_seen, rebuilds, count_writes);
        $display("Included empty pool, null and out-of-range frees, counts 0 to 2047, long stall");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### fixed_chunk_free_list_pool.f
rtl/core/fcfl_pkg.sv
rtl/core/fixed_chunk_free_list_pool.sv
tb/tb.sv
